// ===== rtl/vgte_pkg.sv =====
// Shared types, constants and helpers of the voxel grid triangle emitter.
package vgte_pkg;

	// Default grid size per axis
	localparam int CELLS_X_DEF = 32;
	localparam int CELLS_Y_DEF = 32;
	localparam int CELLS_Z_DEF = 32;

	// Field widths
	localparam int COORD_W = 5;
	localparam int POS_W   = 32;
	localparam int COL_W   = 8;
	localparam int NUM_TRI = 6;

	// Commands
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_VISIT  = 1'b1;

	// Vertex position within a triangle
	localparam logic [1:0] CORNER_SELF = 2'd0;
	localparam logic [1:0] CORNER_DIAG = 2'd1;
	localparam logic [1:0] CORNER_EDGE = 2'd2;

	// Input transaction
	typedef struct packed {
		logic               cmd;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [COORD_W-1:0] cell_z;
		logic [POS_W-1:0]   point_x;
		logic [POS_W-1:0]   point_y;
		logic [POS_W-1:0]   point_z;
		logic [COL_W-1:0]   red_in;
		logic [COL_W-1:0]   green_in;
		logic [COL_W-1:0]   blue_in;
	} req_item_t;

	// Output transaction, one vertex
	typedef struct packed {
		logic [POS_W-1:0] vertex_x;
		logic [POS_W-1:0] vertex_y;
		logic [POS_W-1:0] vertex_z;
		logic [COL_W-1:0] red_out;
		logic [COL_W-1:0] green_out;
		logic [COL_W-1:0] blue_out;
		logic [1:0]       plane;
		logic [1:0]       corner;
		logic             last_vertex;
	} vtx_item_t;

	// Payload word of one grid cell
	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] pos_z;
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
	} cell_data_t;

	// Cell relative to the visited one; also the order of the valid reads
	typedef enum logic [2:0] {
		NB_SELF,
		NB_LEFT,
		NB_DOWN,
		NB_BEFORE,
		NB_DIAG_XY,
		NB_DIAG_XZ,
		NB_DIAG_YZ
	} nb_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SELF_RD,
		ST_SELF_CHK,
		ST_NB_RD,
		ST_NB_CHK,
		ST_VTX_RD,
		ST_VTX_LD,
		ST_VTX_OUT
	} state_t;

	// Grid store port control
	typedef struct packed {
		logic rd_en;
		logic wr_vld_en;
		logic wr_vld_bit;
		logic wr_dat_en;
	} store_ctrl_t;

	// Address bits of one axis; coordinates never exceed COORD_W bits
	function automatic int axis_bits(input int cells);
		int bits;
		bits = $clog2(cells);
		if (bits > COORD_W) begin
			bits = COORD_W;
		end
		return bits;
	endfunction

endpackage

// ===== rtl/vgte_req_if.sv =====
// Valid/ready channel carrying insert and visit commands.
interface vgte_req_if import vgte_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/vgte_vtx_if.sv =====
// Valid/ready channel carrying emitted triangle vertices.
interface vgte_vtx_if import vgte_pkg::*; ();
	logic      valid;
	logic      ready;
	vtx_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/vgte_store.sv =====
// Grid store: valid bit memory and cell payload memory behind one shared port.
module vgte_store import vgte_pkg::*; #(
	parameter int CELLS_X = CELLS_X_DEF,
	parameter int CELLS_Y = CELLS_Y_DEF,
	parameter int CELLS_Z = CELLS_Z_DEF,
	localparam int ADDR_W = axis_bits(CELLS_X) + axis_bits(CELLS_Y) + axis_bits(CELLS_Z)
) (
	input  logic              clk,
	input  logic [ADDR_W-1:0] addr,
	input  store_ctrl_t       ctrl,
	input  cell_data_t        wr_data,
	output logic              vld_rd,
	output cell_data_t        dat_rd
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic       vld_mem [DEPTH];
	cell_data_t dat_mem [DEPTH];
	logic       vld_rd_q;
	cell_data_t dat_rd_q;

	// Valid bits: cleared by the sequencer's sweep, set by inserts
	always_ff @(posedge clk) begin
		if (ctrl.wr_vld_en) begin
			vld_mem[addr] <= ctrl.wr_vld_bit;
		end
		if (ctrl.rd_en) begin
			vld_rd_q <= vld_mem[addr];
		end
	end

	// Cell payload, written once per cell
	always_ff @(posedge clk) begin
		if (ctrl.wr_dat_en) begin
			dat_mem[addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			dat_rd_q <= dat_mem[addr];
		end
	end

	assign vld_rd = vld_rd_q;
	assign dat_rd = dat_rd_q;

endmodule

// ===== rtl/vgte_seq.sv =====
// Sequencer: clear sweep, insert check, neighbor scan and vertex emission.
module vgte_seq import vgte_pkg::*; #(
	parameter int CELLS_X = CELLS_X_DEF,
	parameter int CELLS_Y = CELLS_Y_DEF,
	parameter int CELLS_Z = CELLS_Z_DEF,
	localparam int ADDR_W = axis_bits(CELLS_X) + axis_bits(CELLS_Y) + axis_bits(CELLS_Z)
) (
	input  logic              clk,
	input  logic              arst_n,
	vgte_req_if.sink          req,
	vgte_vtx_if.source        vtx,
	output logic [ADDR_W-1:0] addr,
	output store_ctrl_t       ctrl,
	output cell_data_t        wr_data,
	input  logic              vld_rd,
	input  cell_data_t        dat_rd
);

	localparam int AXW_X = axis_bits(CELLS_X);
	localparam int AXW_Y = axis_bits(CELLS_Y);
	localparam int AXW_Z = axis_bits(CELLS_Z);

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   clr_q;
	req_item_t           item_q;
	nb_t                 nb_q;
	logic [6:0]          vbits_q;
	logic [2:0]          tri_q;
	logic [1:0]          corner_q;
	vtx_item_t           out_q;

	logic                in_range;
	logic                hx, hy, hz;
	logic [2:0]          plane_ok;
	logic [NUM_TRI-1:0]  tri_en;
	logic [NUM_TRI-1:0]  later_mask;
	logic                is_last;
	nb_t                 diag_nb, edge_nb, vtx_nb, sel_nb;
	logic [COORD_W-1:0]  xm, ym, zm, cx, cy, cz;

	// Coordinate check on the incoming transaction
	assign in_range = (32'(req.item.cell_x) < 32'(CELLS_X))
		&& (32'(req.item.cell_y) < 32'(CELLS_Y))
		&& (32'(req.item.cell_z) < 32'(CELLS_Z));

	// Border flags and triangle enables from the gathered valid bits
	assign hx = (item_q.cell_x != '0);
	assign hy = (item_q.cell_y != '0);
	assign hz = (item_q.cell_z != '0);
	assign plane_ok = {hy & hz, hx & hz, hx & hy};

	assign tri_en[0] = plane_ok[0] & vbits_q[NB_DIAG_XY] & vbits_q[NB_DOWN];
	assign tri_en[1] = tri_en[0] & vbits_q[NB_LEFT];
	assign tri_en[2] = plane_ok[1] & vbits_q[NB_DIAG_XZ] & vbits_q[NB_LEFT];
	assign tri_en[3] = tri_en[2] & vbits_q[NB_BEFORE];
	assign tri_en[4] = plane_ok[2] & vbits_q[NB_DIAG_YZ] & vbits_q[NB_DOWN];
	assign tri_en[5] = tri_en[4] & vbits_q[NB_BEFORE];

	// Last vertex: edge corner with no enabled triangle after this one
	always_comb begin
		for (int i = 0; i < NUM_TRI; i++) begin
			later_mask[i] = (3'(i) > tri_q);
		end
		is_last = (corner_q == CORNER_EDGE) && ((tri_en & later_mask) == '0);
	end

	// Cell of the current vertex
	always_comb begin
		unique case (tri_q)
			3'd0: begin diag_nb = NB_DIAG_XY; edge_nb = NB_DOWN;   end
			3'd1: begin diag_nb = NB_DIAG_XY; edge_nb = NB_LEFT;   end
			3'd2: begin diag_nb = NB_DIAG_XZ; edge_nb = NB_LEFT;   end
			3'd3: begin diag_nb = NB_DIAG_XZ; edge_nb = NB_BEFORE; end
			3'd4: begin diag_nb = NB_DIAG_YZ; edge_nb = NB_DOWN;   end
			3'd5: begin diag_nb = NB_DIAG_YZ; edge_nb = NB_BEFORE; end
			default: begin diag_nb = NB_SELF; edge_nb = NB_SELF; end
		endcase
		unique case (corner_q)
			CORNER_SELF: vtx_nb = NB_SELF;
			CORNER_DIAG: vtx_nb = diag_nb;
			default:     vtx_nb = edge_nb;
		endcase
	end

	// Address generator: neighbor selection and coordinate packing
	always_comb begin
		xm = item_q.cell_x - COORD_W'(1);
		ym = item_q.cell_y - COORD_W'(1);
		zm = item_q.cell_z - COORD_W'(1);
		unique case (state_q)
			ST_NB_RD:  sel_nb = nb_q;
			ST_VTX_RD: sel_nb = vtx_nb;
			default:   sel_nb = NB_SELF;
		endcase
		unique case (sel_nb)
			NB_LEFT:    begin cx = xm;            cy = item_q.cell_y; cz = item_q.cell_z; end
			NB_DOWN:    begin cx = item_q.cell_x; cy = ym;            cz = item_q.cell_z; end
			NB_BEFORE:  begin cx = item_q.cell_x; cy = item_q.cell_y; cz = zm;            end
			NB_DIAG_XY: begin cx = xm;            cy = ym;            cz = item_q.cell_z; end
			NB_DIAG_XZ: begin cx = xm;            cy = item_q.cell_y; cz = zm;            end
			NB_DIAG_YZ: begin cx = item_q.cell_x; cy = ym;            cz = zm;            end
			default:    begin cx = item_q.cell_x; cy = item_q.cell_y; cz = item_q.cell_z; end
		endcase
		if (state_q == ST_CLEAR) begin
			addr = clr_q;
		end else begin
			addr = {cx[AXW_X-1:0], cy[AXW_Y-1:0], cz[AXW_Z-1:0]};
		end
	end

	// Insert payload
	assign wr_data = '{pos_x: item_q.point_x, pos_y: item_q.point_y, pos_z: item_q.point_z,
		red: item_q.red_in, green: item_q.green_in, blue: item_q.blue_in};

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, store control and handshakes
	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		req.ready = 1'b0;
		vtx.valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ctrl.wr_vld_en = 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && in_range) begin
					state_d = ST_SELF_RD;
				end
			end
			ST_SELF_RD: begin
				ctrl.rd_en = 1'b1;
				state_d    = ST_SELF_CHK;
			end
			ST_SELF_CHK: begin
				if (item_q.cmd == CMD_INSERT) begin
					ctrl.wr_vld_en  = !vld_rd;
					ctrl.wr_vld_bit = 1'b1;
					ctrl.wr_dat_en  = !vld_rd;
					state_d         = ST_IDLE;
				end else if (vld_rd) begin
					state_d = ST_NB_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_NB_RD: begin
				ctrl.rd_en = 1'b1;
				state_d    = ST_NB_CHK;
			end
			ST_NB_CHK: begin
				state_d = (nb_q == NB_DIAG_YZ) ? ST_VTX_RD : ST_NB_RD;
			end
			ST_VTX_RD: begin
				if (tri_en[tri_q]) begin
					ctrl.rd_en = 1'b1;
					state_d    = ST_VTX_LD;
				end else if (tri_q == 3'(NUM_TRI - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_VTX_LD: begin
				state_d = ST_VTX_OUT;
			end
			ST_VTX_OUT: begin
				vtx.valid = 1'b1;
				if (vtx.ready) begin
					state_d = out_q.last_vertex ? ST_IDLE : ST_VTX_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Counters and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			nb_q     <= NB_LEFT;
			vbits_q  <= '0;
			tri_q    <= '0;
			corner_q <= CORNER_SELF;
		end else begin
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + ADDR_W'(1);
				ST_SELF_CHK: begin
					nb_q     <= NB_LEFT;
					vbits_q  <= '0;
					tri_q    <= '0;
					corner_q <= CORNER_SELF;
				end
				ST_NB_CHK: begin
					vbits_q[nb_q] <= vld_rd;
					nb_q          <= nb_t'(nb_q + 3'd1);
				end
				ST_VTX_RD: begin
					if (!tri_en[tri_q]) begin
						tri_q <= tri_q + 3'd1;
					end
				end
				ST_VTX_OUT: begin
					if (vtx.ready) begin
						if (corner_q == CORNER_EDGE) begin
							tri_q    <= tri_q + 3'd1;
							corner_q <= CORNER_SELF;
						end else begin
							corner_q <= corner_q + 2'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Accepted command and output vertex register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			item_q <= req.item;
		end
		if (state_q == ST_VTX_LD) begin
			out_q.vertex_x    <= dat_rd.pos_x;
			out_q.vertex_y    <= dat_rd.pos_y;
			out_q.vertex_z    <= dat_rd.pos_z;
			out_q.red_out     <= dat_rd.red;
			out_q.green_out   <= dat_rd.green;
			out_q.blue_out    <= dat_rd.blue;
			out_q.plane       <= tri_q[2:1];
			out_q.corner      <= corner_q;
			out_q.last_vertex <= is_last;
		end
	end

	assign vtx.item = out_q;

	// Checks
	a_last_on_edge: assert property (@(posedge clk) disable iff (!arst_n)
		vtx.valid && vtx.item.last_vertex |-> vtx.item.corner == CORNER_EDGE)
		else $error("last vertex flagged on a non-edge corner");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !vtx.valid)
		else $error("command taken while a vertex is pending");

	a_first_wins: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_dat_en |-> !vld_rd)
		else $error("payload write to an occupied cell");

	a_enabled_tri: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_VTX_OUT |-> tri_en[tri_q])
		else $error("vertex emitted for a disabled triangle");

endmodule

// ===== rtl/voxel_grid_triangle_emitter_top.sv =====
// An insert reads the cell's valid bit and then, for an empty cell, writes the valid bit and payload;
// a visit checks the cell, then makes the six neighbor valid reads, then reads, loads and presents
// each emitted vertex, waiting out output stalls, and skips disabled triangle slots, all on one port.
// One transaction is in flight at a time; req.ready is high only when idle.
// After arst_n the whole valid memory is swept, one cell per cycle, before
// the first command is taken.
module voxel_grid_triangle_emitter_top import vgte_pkg::*; #(
	parameter int CELLS_X = CELLS_X_DEF,
	parameter int CELLS_Y = CELLS_Y_DEF,
	parameter int CELLS_Z = CELLS_Z_DEF
) (
	input logic        clk,
	input logic        arst_n,
	vgte_req_if.sink   req,
	vgte_vtx_if.source vtx
);

	localparam int ADDR_W = axis_bits(CELLS_X) + axis_bits(CELLS_Y) + axis_bits(CELLS_Z);

	logic [ADDR_W-1:0] addr;
	store_ctrl_t       ctrl;
	cell_data_t        wr_data;
	logic              vld_rd;
	cell_data_t        dat_rd;

	// Control sequencer and address generator
	vgte_seq #(
		.CELLS_X(CELLS_X),
		.CELLS_Y(CELLS_Y),
		.CELLS_Z(CELLS_Z)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.vtx     (vtx),
		.addr    (addr),
		.ctrl    (ctrl),
		.wr_data (wr_data),
		.vld_rd  (vld_rd),
		.dat_rd  (dat_rd)
	);

	// Grid memories
	vgte_store #(
		.CELLS_X(CELLS_X),
		.CELLS_Y(CELLS_Y),
		.CELLS_Z(CELLS_Z)
	) u_store (
		.clk     (clk),
		.addr    (addr),
		.ctrl    (ctrl),
		.wr_data (wr_data),
		.vld_rd  (vld_rd),
		.dat_rd  (dat_rd)
	);

endmodule

// ===== test/voxel_grid_triangle_emitter_top_tb.sv =====
// Self-checking testbench of the voxel grid triangle emitter: insert/visit stimulus, vertex checks.
`timescale 1ns / 1ps

module voxel_grid_triangle_emitter_top_tb;
	import vgte_pkg::*;

	// Plane codes of the vertex stream
	localparam logic [1:0] PLANE_XOY = 2'd0;
	localparam logic [1:0] PLANE_XOZ = 2'd1;
	localparam logic [1:0] PLANE_YOZ = 2'd2;

	localparam int NUM_CELLS   = CELLS_X_DEF * CELLS_Y_DEF * CELLS_Z_DEF;
	localparam int IDLE_PCT    = 38;
	localparam int RAND_ITEMS  = 136;
	localparam int DRAIN_CYC   = 100;
	localparam int CALM_FIRST  = 70;
	localparam int CALM_LAST   = 110;

	logic clk;
	logic arst_n;

	vgte_req_if req_ch ();
	vgte_vtx_if vtx_ch ();

	voxel_grid_triangle_emitter_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.vtx    (vtx_ch)
	);

	// Shadow copy of the grid
	bit         grid_full [NUM_CELLS];
	cell_data_t grid_data [NUM_CELLS];

	req_item_t pending_cmds[$];
	vtx_item_t expected_vertices[$];
	vtx_item_t visit_buf[$];

	int n_accepted;
	int n_errors;
	bit calm;

	assign calm = (n_accepted >= CALM_FIRST) && (n_accepted < CALM_LAST);

	function automatic int cell_idx(int x, int y, int z);
		return (x * CELLS_Y_DEF + y) * CELLS_Z_DEF + z;
	endfunction

	function automatic vtx_item_t grid_vertex(int idx, logic [1:0] pl, logic [1:0] cn);
		vtx_item_t v;
		v.vertex_x    = grid_data[idx].pos_x;
		v.vertex_y    = grid_data[idx].pos_y;
		v.vertex_z    = grid_data[idx].pos_z;
		v.red_out     = grid_data[idx].red;
		v.green_out   = grid_data[idx].green;
		v.blue_out    = grid_data[idx].blue;
		v.plane       = pl;
		v.corner      = cn;
		v.last_vertex = 1'b0;
		return v;
	endfunction

	task automatic emit_triangle(int self_i, int diag_i, int edge_i, logic [1:0] pl);
		visit_buf.insert(visit_buf.size(), grid_vertex(self_i, pl, CORNER_SELF));
		visit_buf.insert(visit_buf.size(), grid_vertex(diag_i, pl, CORNER_DIAG));
		visit_buf.insert(visit_buf.size(), grid_vertex(edge_i, pl, CORNER_EDGE));
	endtask

	// One plane: first triangle needs diagonal and first edge, second adds the other edge
	task automatic emit_plane(bit ok, int self_i, int diag_i, int e1_i, int e2_i,
			logic [1:0] pl);
		if (!ok || !grid_full[diag_i] || !grid_full[e1_i]) begin
			return;
		end
		emit_triangle(self_i, diag_i, e1_i, pl);
		if (grid_full[e2_i]) begin
			emit_triangle(self_i, diag_i, e2_i, pl);
		end
	endtask

	// Updates the shadow grid and queues the vertices an accepted command causes
	task automatic predict_vertices(req_item_t it);
		int  x, y, z, xl, yd, zb, self_i, left_i, down_i, before_i;
		bit  hx, hy, hz;
		x      = int'(it.cell_x);
		y      = int'(it.cell_y);
		z      = int'(it.cell_z);
		self_i = cell_idx(x, y, z);
		if (it.cmd == CMD_INSERT) begin
			// first point into a cell wins
			if (!grid_full[self_i]) begin
				grid_full[self_i]       = 1'b1;
				grid_data[self_i].pos_x = it.point_x;
				grid_data[self_i].pos_y = it.point_y;
				grid_data[self_i].pos_z = it.point_z;
				grid_data[self_i].red   = it.red_in;
				grid_data[self_i].green = it.green_in;
				grid_data[self_i].blue  = it.blue_in;
			end
			return;
		end
		if (!grid_full[self_i]) begin
			return;
		end
		hx       = x > 0;
		hy       = y > 0;
		hz       = z > 0;
		xl       = hx ? x - 1 : 0;
		yd       = hy ? y - 1 : 0;
		zb       = hz ? z - 1 : 0;
		left_i   = cell_idx(xl, y, z);
		down_i   = cell_idx(x, yd, z);
		before_i = cell_idx(x, y, zb);
		visit_buf.delete();
		emit_plane(hx && hy, self_i, cell_idx(xl, yd, z), down_i, left_i, PLANE_XOY);
		emit_plane(hx && hz, self_i, cell_idx(xl, y, zb), left_i, before_i, PLANE_XOZ);
		emit_plane(hy && hz, self_i, cell_idx(x, yd, zb), down_i, before_i, PLANE_YOZ);
		if (visit_buf.size() > 0) begin
			visit_buf[visit_buf.size() - 1].last_vertex = 1'b1;
		end
		foreach (visit_buf[i]) begin
			expected_vertices.insert(expected_vertices.size(), visit_buf[i]);
		end
	endtask

	task automatic push_cmd(logic cmd, int x, int y, int z, logic [31:0] px,
			logic [31:0] py, logic [31:0] pz, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		req_item_t it;
		it.cmd      = cmd;
		it.cell_x   = COORD_W'(x);
		it.cell_y   = COORD_W'(y);
		it.cell_z   = COORD_W'(z);
		it.point_x  = px;
		it.point_y  = py;
		it.point_z  = pz;
		it.red_in   = r;
		it.green_in = g;
		it.blue_in  = b;
		pending_cmds.insert(pending_cmds.size(), it);
	endtask

	function automatic req_item_t rand_cmd(logic cmd, int x, int y, int z);
		req_item_t it;
		it.cmd      = cmd;
		it.cell_x   = COORD_W'(x);
		it.cell_y   = COORD_W'(y);
		it.cell_z   = COORD_W'(z);
		it.point_x  = $urandom;
		it.point_y  = $urandom;
		it.point_z  = $urandom;
		it.red_in   = COL_W'($urandom_range(0, 255));
		it.green_in = COL_W'($urandom_range(0, 255));
		it.blue_in  = COL_W'($urandom_range(0, 255));
		return it;
	endfunction

	// Coordinate biased toward the grid borders
	function automatic int rand_coord();
		int sel;
		sel = int'($urandom_range(0, 9));
		if (sel == 0) begin
			return 0;
		end else if (sel == 1) begin
			return CELLS_X_DEF - 1;
		end
		return int'($urandom_range(0, CELLS_X_DEF - 1));
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			n_errors++;
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Reset, released on a falling clock edge
	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: request transactions from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.item  <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predict_vertices(req_ch.item);
				n_accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					req_ch.valid <= 1'b1;
					req_ch.item  <= pending_cmds.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: vertex transactions against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		vtx_item_t exp_v;
		if (!arst_n) begin
			vtx_ch.ready <= 1'b0;
		end else begin
			if (vtx_ch.valid && vtx_ch.ready) begin
				if (expected_vertices.size() == 0) begin
					$display("%0t: unexpected vertex, expected none, actual %h", $time,
						vtx_ch.item);
					n_errors++;
				end else begin
					exp_v = expected_vertices.pop_front();
					check_field("vertex_x", exp_v.vertex_x, vtx_ch.item.vertex_x);
					check_field("vertex_y", exp_v.vertex_y, vtx_ch.item.vertex_y);
					check_field("vertex_z", exp_v.vertex_z, vtx_ch.item.vertex_z);
					check_field("red_out", 32'(exp_v.red_out), 32'(vtx_ch.item.red_out));
					check_field("green_out", 32'(exp_v.green_out),
						32'(vtx_ch.item.green_out));
					check_field("blue_out", 32'(exp_v.blue_out), 32'(vtx_ch.item.blue_out));
					check_field("plane", 32'(exp_v.plane), 32'(vtx_ch.item.plane));
					check_field("corner", 32'(exp_v.corner), 32'(vtx_ch.item.corner));
					check_field("last_vertex", 32'(exp_v.last_vertex),
						32'(vtx_ch.item.last_vertex));
				end
			end
			vtx_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Stimulus and end of run
	initial begin
		int        bx, by, bz, cx, cy, cz, n_dir;
		bit        have_base;
		req_item_t seq[$];
		n_accepted = 0;
		n_errors   = 0;
		have_base  = 1'b0;

		// Empty cell, then a corner cell that can never form triangles
		push_cmd(CMD_VISIT, 0, 0, 0, '0, '0, '0, '0, '0, '0);
		push_cmd(CMD_INSERT, 0, 0, 0, '0, '0, '0, '0, '0, '0);
		push_cmd(CMD_INSERT, 0, 0, 0, '1, '1, '1, '1, '1, '1);
		push_cmd(CMD_VISIT, 0, 0, 0, '1, '1, '1, '1, '1, '1);
		// Full cube at the top corner: all six triangles
		for (int o = 7; o >= 0; o--) begin
			push_cmd(CMD_INSERT, 31 - o[0], 31 - o[1], 31 - o[2],
				(o[0] ? 32'hFFFF_FFFF : 32'h8000_0001), 32'h7FFF_FFFF ^ 32'(o),
				32'hA5A5_5A5A + 32'(o), 8'(8'hFF - o), 8'(8'h80 + o), 8'(8'h01 << o));
		end
		push_cmd(CMD_VISIT, 31, 31, 31, '0, '0, '0, '0, '0, '0);
		// Partial neighborhood: one triangle, then a second once the other edge fills
		push_cmd(CMD_INSERT, 1, 1, 1, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333,
			8'h11, 8'h22, 8'h33);
		push_cmd(CMD_INSERT, 0, 0, 1, 32'h4444_4444, 32'h5555_5555, 32'h6666_6666,
			8'h44, 8'h55, 8'h66);
		push_cmd(CMD_INSERT, 1, 0, 1, 32'h7777_7777, 32'h8888_8888, 32'h9999_9999,
			8'h77, 8'h88, 8'h99);
		push_cmd(CMD_VISIT, 1, 1, 1, '0, '0, '0, '0, '0, '0);
		push_cmd(CMD_INSERT, 0, 1, 1, 32'hAAAA_AAAA, 32'hBBBB_BBBB, 32'hCCCC_CCCC,
			8'hAA, 8'hBB, 8'hCC);
		push_cmd(CMD_VISIT, 1, 1, 1, '0, '0, '0, '0, '0, '0);
		// Low y border: only the xoz plane can emit
		pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_INSERT, 5, 0, 7));
		pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_INSERT, 4, 0, 6));
		pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_INSERT, 4, 0, 7));
		pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_INSERT, 5, 0, 6));
		pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_VISIT, 5, 0, 7));
		n_dir = pending_cmds.size();

		// Random part: mostly filled neighborhoods followed by visits, some noise
		while (pending_cmds.size() < n_dir + RAND_ITEMS) begin
			if ($urandom_range(0, 99) < 75) begin
				if (!(have_base && $urandom_range(0, 4) == 0)) begin
					bx = rand_coord();
					by = rand_coord();
					bz = rand_coord();
				end
				have_base = 1'b1;
				seq.delete();
				for (int o = 0; o < 8; o++) begin
					if (o == 0 ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 3) == 0)) begin
						continue;
					end
					if (o[0] > bx || o[1] > by || o[2] > bz) begin
						continue;
					end
					cx = bx - o[0];
					cy = by - o[1];
					cz = bz - o[2];
					if ($urandom_range(0, 1)) begin
						seq.push_front(rand_cmd(CMD_INSERT, cx, cy, cz));
					end else begin
						seq.insert(seq.size(), rand_cmd(CMD_INSERT, cx, cy, cz));
					end
				end
				foreach (seq[i]) begin
					pending_cmds.insert(pending_cmds.size(), seq[i]);
				end
				pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_VISIT, bx, by, bz));
				if ($urandom_range(0, 2) == 0) begin
					pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_VISIT,
						bx - ((bx > 0) ? int'($urandom_range(0, 1)) : 0),
						by - ((by > 0) ? int'($urandom_range(0, 1)) : 0),
						bz - ((bz > 0) ? int'($urandom_range(0, 1)) : 0)));
				end
			end else begin
				pending_cmds.insert(pending_cmds.size(), rand_cmd(1'($urandom_range(0, 1)),
					int'($urandom_range(0, 31)), int'($urandom_range(0, 31)),
					int'($urandom_range(0, 31))));
			end
		end

		// Drain: all commands taken, all vertices seen, then a quiet period
		@(posedge arst_n);
		do begin
			@(negedge clk);
		end while (pending_cmds.size() > 0 || req_ch.valid || expected_vertices.size() > 0);
		repeat (DRAIN_CYC) @(posedge clk);
		@(negedge clk);
		if (n_errors == 0 && expected_vertices.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
